>>> hdl/pdep_pkg.sv
// Shared types and constants for the packed directory entry parser.
package pdep_pkg;

    // Configuration port geometry: three registers on an 8-byte pitch
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_ADDR_MODE = 2'd0;
    localparam logic [1:0] REG_DISK_SIZE = 2'd1;
    localparam logic [1:0] REG_TYPE_MASK = 2'd2;

    localparam logic [7:0] TYPE_MASK_RESET = 8'hFE;

    // Entry layout and checks
    localparam int unsigned POS_W        = 9;
    localparam logic [7:0]  NAME_CHAR_MIN = 8'h20;
    localparam logic [7:0]  NAME_CHAR_MAX = 8'h7E;
    localparam logic [7:0]  TYPE_CODE_MAX = 8'd7;
    localparam logic [POS_W-1:0] HDR_BYTES    = 9'd2;
    localparam logic [POS_W-1:0] ADDR_BYTES32 = 9'd4;
    localparam logic [POS_W-1:0] ADDR_BYTES64 = 9'd8;
    localparam logic [15:0] DELETED_MARK = 16'hFFFF;
    localparam logic [63:0] LOW32_MASK   = 64'h0000_0000_FFFF_FFFF;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_NAME = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd3;

    typedef struct packed {
        logic        addr_is_64bit;
        logic [63:0] disk_size;
        logic [7:0]  type_valid_mask;
    } cfg_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic consume;
        logic fire_result;
        logic active;
    } stat_t;

endpackage

>>> hdl/pdep_ifs.sv
// Valid/ready channel interfaces for entry bytes and parse results.
interface pdep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       entry_start;

    modport source (output valid, output data_byte, output entry_start, input ready);
    modport sink   (input valid, input data_byte, input entry_start, output ready);
endinterface

interface pdep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  name_length;
    logic [7:0]  file_type_code;
    logic [63:0] entry_address;
    logic        is_deleted;

    modport source (output valid, output status, output name_length,
                    output file_type_code, output entry_address, output is_deleted,
                    input ready);
    modport sink   (input valid, input status, input name_length,
                    input file_type_code, input entry_address, input is_deleted,
                    output ready);
endinterface

>>> hdl/pdep_cfg_regs.sv
// APB configuration registers for the entry parser.
module pdep_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdep_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pdep_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pdep_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pdep_pkg::cfg_t                    cfg
);
    import pdep_pkg::*;

    logic        addr_mode_reg;
    logic [63:0] disk_size_reg;
    logic [7:0]  type_mask_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_mode_reg <= 1'b0;
            disk_size_reg <= '0;
            type_mask_reg <= TYPE_MASK_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ADDR_MODE: addr_mode_reg <= pwdata[0];
                REG_DISK_SIZE: disk_size_reg <= pwdata;
                REG_TYPE_MASK: type_mask_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_ADDR_MODE: prdata = {63'd0, addr_mode_reg};
            REG_DISK_SIZE: prdata = disk_size_reg;
            REG_TYPE_MASK: prdata = {56'd0, type_mask_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg = '{addr_is_64bit: addr_mode_reg,
                   disk_size: disk_size_reg,
                   type_valid_mask: type_mask_reg};

endmodule

>>> hdl/pdep_parser.sv
// Entry byte parser: input register, per-byte state update, result register.
module pdep_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  pdep_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           entry_start,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [1:0]     status,
    output logic [7:0]     name_length,
    output logic [7:0]     file_type_code,
    output logic [63:0]    entry_address,
    output logic           is_deleted,
    output pdep_pkg::stat_t stat
);
    import pdep_pkg::*;

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Parse state
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [7:0]       len_reg,  len_next;
    logic             prt_reg,  prt_next;
    logic [7:0]       type_reg, type_next;
    logic [63:0]      shift_reg, shift_next;
    logic             active_reg, active_next;

    // Result register
    logic        res_vld_reg;
    logic [1:0]  status_reg;
    logic [7:0]  len_out_reg;
    logic [7:0]  type_out_reg;
    logic [63:0] addr_out_reg;
    logic        del_out_reg;

    // Per-byte decode
    logic [POS_W-1:0] p_eff, type_pos, addr_count, need;
    logic [7:0]       len_eff, type_eff;
    logic             prt_eff, active_eff;
    logic [63:0]      shift_eff, shift_new, addr_val;
    logic             is_len, is_skip, is_name, is_type, is_addr;
    logic             done, consume, fire, deleted, type_ok, addr_ok, bad_char;
    logic [1:0]       status_val;

    // A start byte sees a freshly cleared entry
    always_comb
    begin
        p_eff      = in_start_reg ? '0    : pos_reg;
        len_eff    = in_start_reg ? '0    : len_reg;
        prt_eff    = in_start_reg ? 1'b1  : prt_reg;
        type_eff   = in_start_reg ? '0    : type_reg;
        shift_eff  = in_start_reg ? '0    : shift_reg;
        active_eff = in_start_reg || active_reg;

        type_pos   = HDR_BYTES + {1'b0, len_eff};
        is_len     = (p_eff == '0);
        is_skip    = (p_eff == 9'd1);
        is_name    = !is_len && !is_skip && (p_eff < type_pos);
        is_type    = (p_eff == type_pos);
        is_addr    = !is_len && !is_skip && (p_eff > type_pos);
        addr_count = p_eff - type_pos;
        need       = cfg.addr_is_64bit ? ADDR_BYTES64 : ADDR_BYTES32;
        shift_new  = {shift_eff[55:0], in_byte_reg};
        done       = active_eff && is_addr && (addr_count >= need);
        bad_char   = (in_byte_reg < NAME_CHAR_MIN) || (in_byte_reg > NAME_CHAR_MAX);

        addr_val   = cfg.addr_is_64bit ? shift_new : (shift_new & LOW32_MASK);
        deleted    = (addr_val[15:0] == DELETED_MARK);
        type_ok    = (type_eff <= TYPE_CODE_MAX) && cfg.type_valid_mask[type_eff[2:0]];
        addr_ok    = deleted || ((addr_val != '0) && (addr_val <= cfg.disk_size));

        if (!prt_eff)
            status_val = STATUS_BAD_NAME;
        else if (!type_ok)
            status_val = STATUS_BAD_TYPE;
        else if (!addr_ok)
            status_val = STATUS_BAD_ADDR;
        else
            status_val = STATUS_OK;
    end

    // A byte that makes no result never waits on the result register
    assign consume  = in_vld_reg && (!done || !res_vld_reg || res_ready);
    assign fire     = consume && done;
    assign in_ready = !in_vld_reg || consume;

    // Next parse state
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        prt_next    = prt_reg;
        type_next   = type_reg;
        shift_next  = shift_reg;
        active_next = active_reg;
        if (consume && active_eff)
        begin
            len_next    = is_len  ? in_byte_reg : len_eff;
            prt_next    = (is_name && bad_char) ? 1'b0 : prt_eff;
            type_next   = is_type ? in_byte_reg : type_eff;
            shift_next  = is_addr ? shift_new   : shift_eff;
            pos_next    = done ? '0 : p_eff + 9'd1;
            active_next = !done;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= entry_start;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            prt_reg    <= 1'b1;
            type_reg   <= '0;
            shift_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            prt_reg    <= prt_next;
            type_reg   <= type_next;
            shift_reg  <= shift_next;
            active_reg <= active_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (fire)
            res_vld_reg <= 1'b1;
        else if (res_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_val;
            len_out_reg  <= len_eff;
            type_out_reg <= type_eff;
            addr_out_reg <= addr_val;
            del_out_reg  <= deleted;
        end
    end

    assign res_valid      = res_vld_reg;
    assign status         = status_reg;
    assign name_length    = len_out_reg;
    assign file_type_code = type_out_reg;
    assign entry_address  = addr_out_reg;
    assign is_deleted     = del_out_reg;

    assign stat = '{consume: consume, fire_result: fire, active: active_reg};

endmodule

>>> hdl/packed_dir_entry_parser_unit.sv
// Top level of the packed directory entry parser.
//
//  channel        | dir    | word
//  ---------------+--------+---------------------------------------------
//  entry_bytes    | sink   | data_byte, entry_start
//  entry_results  | source | status, name_length, file_type_code,
//                 |        | entry_address, is_deleted
//  APB            | slave  | addr_is_64bit @0, disk_size @8, type_valid_mask @16
//
// One byte per cycle sustained. Each byte passes an input register and then
// updates the parse state; the last address byte loads the result register.
// Bytes that produce no result move on even while a result is stalled; only
// the closing byte of an entry waits for the result register to drain.
// Reset clears the parse state and the registers (type mask 0xFE); no
// clearing pass.
module packed_dir_entry_parser_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pdep_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pdep_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    pdep_in_if.sink                         entry_bytes,
    pdep_out_if.source                      entry_results
);
    import pdep_pkg::*;

    cfg_t  cfg;
    stat_t stat;

    pdep_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdep_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (entry_bytes.valid),
        .in_ready       (entry_bytes.ready),
        .data_byte      (entry_bytes.data_byte),
        .entry_start    (entry_bytes.entry_start),
        .res_valid      (entry_results.valid),
        .res_ready      (entry_results.ready),
        .status         (entry_results.status),
        .name_length    (entry_results.name_length),
        .file_type_code (entry_results.file_type_code),
        .entry_address  (entry_results.entry_address),
        .is_deleted     (entry_results.is_deleted),
        .stat           (stat)
    );

    // A finished entry shows up on the result side next cycle
    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire_result |=> entry_results.valid)
        else $error("result not loaded after entry end");

    // Parser goes idle once an entry completes
    a_fire_idles: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire_result |=> !stat.active)
        else $error("parser still active after entry end");

    // A held byte only waits on a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!stat.consume && !entry_bytes.ready)
        |-> (entry_results.valid && !entry_results.ready))
        else $error("input stalled with result side free");

    // An OK, live entry carries an address inside the disk
    a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_results.valid && entry_results.status == STATUS_OK &&
         !entry_results.is_deleted)
        |-> (entry_results.entry_address != '0 &&
             entry_results.entry_address <= cfg.disk_size))
        else $error("OK status with out-of-range address");

    // Deleted flag agrees with the reported address
    a_del_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_results.valid && entry_results.is_deleted)
        |-> (entry_results.entry_address[15:0] == DELETED_MARK))
        else $error("deleted flag without deleted mark");

endmodule
